// ===== rtl/tskf_pkg.sv =====
// Shared widths, reset values, register codes and status types of the three-axis
// smoothing Kalman filter. No dependencies; every other RTL file uses it.
`default_nettype none

package tskf_pkg;

  localparam int AXES       = 3;
  localparam int SAMPLE_W   = 16;                 // Q4.11 sample and estimate
  localparam int REG_W      = 16;                 // Q0.16 configuration registers
  localparam int COV_W      = 18;                 // Q2.16 error covariance
  localparam int GAIN_W     = 17;                 // Q1.16 gain, 0 .. 1.0 inclusive
  localparam int FRAC_W     = 16;
  localparam int MC_W       = COV_W + 1;          // signed multiplicand
  localparam int MP_W       = GAIN_W;             // unsigned multiplier
  localparam int PROD_W     = MC_W + MP_W;
  localparam int MUL_DIGIT_W = 4;                 // multiplier bits consumed per cycle

  localparam int ADDR_W     = 4;
  localparam int REG_LSB    = 2;
  localparam int DATA_W     = 32;

  localparam int ALPHA_RST  = 39322;
  localparam int Q_RST      = 655;
  localparam int R_RST      = 1311;
  localparam int COV_RST    = 65536;
  localparam int COV_MAX    = 262143;
  localparam int GAIN_ONE   = 65536;
  localparam int ROUND_HALF = 32768;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_Q     = 2'd1,
    REG_R     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tskf_if.sv =====
// Valid/ready channel interfaces for samples in and estimates out.
// Depends on tskf_pkg for the field width.
`default_nettype none

interface tskf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tskf_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [tskf_pkg::SAMPLE_W-1:0] accel_y;
  logic signed [tskf_pkg::SAMPLE_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface tskf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tskf_pkg::SAMPLE_W-1:0] filtered_x;
  logic signed [tskf_pkg::SAMPLE_W-1:0] filtered_y;
  logic signed [tskf_pkg::SAMPLE_W-1:0] filtered_z;

  modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                  input ready);
  modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tskf_mul.sv =====
// Digit-serial signed-by-unsigned multiplier, DIGIT_W multiplier bits per cycle.
// Depends on tskf_pkg for operand widths and the status struct.
`default_nettype none

module tskf_mul #(
  parameter int DIGIT_W = tskf_pkg::MUL_DIGIT_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [tskf_pkg::MC_W-1:0]   mcand,
  input  logic        [tskf_pkg::MP_W-1:0]   mplier,
  output logic signed [tskf_pkg::PROD_W-1:0] prod,
  output tskf_pkg::unit_stat_t               stat
);
  import tskf_pkg::*;

  localparam int STEPS = (MP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int LO_W  = STEPS * DIGIT_W;
  localparam int HI_W  = MC_W + DIGIT_W + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic signed [MC_W-1:0]      mcand_r;
  logic signed [HI_W-1:0]      hi_r, hi_nxt;
  logic        [LO_W-1:0]      lo_r, lo_nxt;
  logic        [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic signed [HI_W-1:0]      part_w, sum_w;
  logic        [HI_W+LO_W-1:0] full_w;

  // one partial product per cycle; low digit of the sum drops into the low word
  assign part_w = mcand_r * $signed({1'b0, lo_r[DIGIT_W-1:0]});
  assign sum_w  = hi_r + part_w;
  assign full_w = {hi_r, lo_r};
  assign prod   = $signed(full_w[PROD_W-1:0]);
  assign stat   = '{busy: (cnt_r != '0), done: done_r};

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt  = '0;
      lo_nxt  = LO_W'(mplier);
      cnt_nxt = CNT_W'(STEPS);
    end else if (cnt_r != '0) begin
      hi_nxt   = sum_w >>> DIGIT_W;
      lo_nxt   = {sum_w[DIGIT_W-1:0], lo_r[LO_W-1:DIGIT_W]};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) mcand_r <= mcand;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/tskf_div.sv =====
// Radix-2 restoring divider for the gain: quot = floor(num * 2^16 / den), num <= den.
// Depends on tskf_pkg for widths and the status struct.
`default_nettype none

module tskf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tskf_pkg::COV_W-1:0]        num,
  input  logic [tskf_pkg::COV_W:0]          den,
  output logic [tskf_pkg::GAIN_W-1:0]       quot,
  output tskf_pkg::unit_stat_t              stat
);
  import tskf_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [COV_W+1:0]  rem_r, rem_nxt;
  logic [COV_W:0]    den_r;
  logic [GAIN_W-1:0] q_r, q_nxt;
  logic              zero_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic              ge_w;
  logic [COV_W+1:0]  diff_w, keep_w;

  assign ge_w   = rem_r >= {1'b0, den_r};
  assign diff_w = rem_r - {1'b0, den_r};
  assign keep_w = ge_w ? diff_w : rem_r;
  // zero divisor only when every operand is zero: hold the gain at zero
  assign quot   = zero_r ? '0 : q_r;
  assign stat   = '{busy: (cnt_r != '0), done: done_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = {2'b00, num};
      q_nxt   = '0;
      cnt_nxt = CNT_W'(GAIN_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = {keep_w[COV_W:0], 1'b0};
      q_nxt    = {q_r[GAIN_W-2:0], ge_w};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      zero_r <= (den == '0);
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/three_axis_smoothing_kalman_filter.sv =====
// Three-axis accelerometer smoother with a shared scalar Kalman update.
// Depends on tskf_pkg, the channel interfaces in tskf_if, tskf_mul and tskf_div.
//
// Usage:
//   in_ch  (sink)   : one transaction carries accel_x/y/z, signed Q4.11 G.
//   out_ch (source) : one transaction per input, filtered_x/y/z, signed Q4.11 G.
//   APB port        : alpha at 0x0, process noise q at 0x4, measurement noise r
//                     at 0x8, low 16 bits kept, paddr[1:0] ignored, 0xC ignored on
//                     write and read as zero. Write only while the block is idle.
// Timing:
//   in_ch.ready is high only in the idle state. After acceptance the block runs
//   one 17-step gain division and seven multiplications through one shared
//   digit-serial multiplier, then moves to a done state that loads the result
//   into the out_ch register; a new sample is taken only after that load.
//   The divider and the shared multiplier set the pace.
// Reset (synchronous, rst_n low): estimates clear to zero, covariance to 1.0,
//   registers to their defaults, both channels go empty.
// Stall: the result sits in an output register, so a new sample is taken while
//   out_ch is stalled; the next result waits in its last state until the
//   register frees up.
`default_nettype none

module three_axis_smoothing_kalman_filter #(
  parameter int DIGIT_W = tskf_pkg::MUL_DIGIT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tskf_in_if.sink                       in_ch,
  tskf_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tskf_pkg::ADDR_W-1:0]   paddr,
  input  logic [tskf_pkg::DATA_W-1:0]   pwdata,
  output logic [tskf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tskf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL_A = 7'b0001000,
    S_MUL_K = 7'b0010000,
    S_MUL_P = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  // ---------------------------------------------------------------- config
  logic [REG_W-1:0] alpha_r, q_r, r_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[REG_LSB+1:REG_LSB]);

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA: prdata = DATA_W'(alpha_r);
      REG_Q:     prdata = DATA_W'(q_r);
      REG_R:     prdata = DATA_W'(r_r);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= REG_W'(ALPHA_RST);
      q_r     <= REG_W'(Q_RST);
      r_r     <= REG_W'(R_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA: alpha_r <= pwdata[REG_W-1:0];
        REG_Q:     q_r     <= pwdata[REG_W-1:0];
        REG_R:     r_r     <= pwdata[REG_W-1:0];
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath state
  state_t                   state_r, state_nxt;
  logic                     start_r, start_nxt;
  logic [1:0]               ax_r, ax_nxt;
  logic signed [SAMPLE_W-1:0] x_r   [AXES];
  logic signed [SAMPLE_W-1:0] est_r [AXES];
  logic signed [SAMPLE_W-1:0] res_r [AXES];
  logic                     out_valid_r;
  logic [COV_W-1:0]         cov_r, pp_r;
  logic [GAIN_W-1:0]        k_r;
  logic signed [GAIN_W-1:0] dse_r;         // smoothed sample minus estimate

  logic                     in_fire, out_load;
  logic [COV_W:0]           pred_w, den_w;
  logic [COV_W-1:0]         pp_w;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // predicted covariance P + q, saturated; gain denominator P' + r
  assign pred_w = {1'b0, cov_r} + (COV_W+1)'(q_r);
  assign pp_w   = pred_w[COV_W] ? COV_W'(COV_MAX) : pred_w[COV_W-1:0];
  assign den_w  = {1'b0, pp_r} + (COV_W+1)'(r_r);

  // ---------------------------------------------------------------- shared units
  unit_stat_t                mul_stat, div_stat;
  logic signed [MC_W-1:0]    mul_mcand;
  logic        [MP_W-1:0]    mul_mplier;
  logic signed [PROD_W-1:0]  mul_prod;
  logic        [GAIN_W-1:0]  div_quot;
  logic signed [GAIN_W-1:0]  diff_w;
  logic signed [SAMPLE_W-1:0] est_cur;

  assign est_cur = est_r[ax_r];
  assign diff_w  = GAIN_W'(x_r[ax_r]) - GAIN_W'(est_cur);

  always_comb begin
    unique case (state_r)
      S_MUL_A: begin
        mul_mcand  = MC_W'(diff_w);
        mul_mplier = MP_W'(alpha_r);
      end
      S_MUL_K: begin
        mul_mcand  = MC_W'(dse_r);
        mul_mplier = k_r;
      end
      S_MUL_P: begin
        mul_mcand  = $signed({1'b0, pp_r});
        mul_mplier = MP_W'(GAIN_ONE) - k_r;
      end
      default: begin
        mul_mcand  = '0;
        mul_mplier = '0;
      end
    endcase
  end

  tskf_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r && (state_r == S_MUL_A || state_r == S_MUL_K || state_r == S_MUL_P)),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .prod   (mul_prod),
    .stat   (mul_stat)
  );

  tskf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r && (state_r == S_DIV)),
    .num   (pp_r),
    .den   (den_w),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // round to nearest on the Q16 boundary, ties upward: floor((p + 0.5) / 2^16)
  logic signed [PROD_W-1:0]   rnd_w;
  logic signed [GAIN_W-1:0]   rnd_g;
  logic signed [SAMPLE_W+1:0] ne_w;
  logic signed [SAMPLE_W-1:0] ne_sat;

  assign rnd_w = mul_prod + $signed(PROD_W'(ROUND_HALF));
  assign rnd_g = $signed(rnd_w[FRAC_W+GAIN_W-1:FRAC_W]);
  assign ne_w  = (SAMPLE_W+2)'(est_cur) + (SAMPLE_W+2)'(rnd_g);

  always_comb begin
    if (ne_w > (SAMPLE_W+2)'(32767)) begin
      ne_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (ne_w < -(SAMPLE_W+2)'(32768)) begin
      ne_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      ne_sat = ne_w[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    ax_nxt    = ax_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_DIV;
        start_nxt = 1'b1;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_MUL_A;
          start_nxt = 1'b1;
          ax_nxt    = '0;
        end
      end
      S_MUL_A: begin
        if (mul_stat.done) begin
          state_nxt = S_MUL_K;
          start_nxt = 1'b1;
        end
      end
      S_MUL_K: begin
        if (mul_stat.done) begin
          start_nxt = 1'b1;
          if (ax_r == LAST_AXIS) begin
            state_nxt = S_MUL_P;
          end else begin
            state_nxt = S_MUL_A;
            ax_nxt    = ax_r + 2'd1;
          end
        end
      end
      S_MUL_P: begin
        if (mul_stat.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      cov_r       <= COV_W'(COV_RST);
      for (int i = 0; i < AXES; i++) est_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      ax_r    <= ax_nxt;
      // hold the result until taken; a fresh load wins over a drain
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_MUL_K && mul_stat.done) est_r[ax_r] <= ne_sat;
      // P = P' * (1 - K), rounded; never above P'
      if (state_r == S_MUL_P && mul_stat.done) cov_r <= rnd_w[FRAC_W+COV_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r[0] <= in_ch.accel_x;
      x_r[1] <= in_ch.accel_y;
      x_r[2] <= in_ch.accel_z;
      pp_r   <= pp_w;
    end
    if (state_r == S_DIV && div_stat.done) k_r <= div_quot;
    // a * (x - e) rounded is exactly s - e
    if (state_r == S_MUL_A && mul_stat.done) dse_r <= rnd_g;
    if (out_load) begin
      for (int i = 0; i < AXES; i++) res_r[i] <= est_r[i];
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.filtered_x = res_r[0];
  assign out_ch.filtered_y = res_r[1];
  assign out_ch.filtered_z = res_r[2];

  // ---------------------------------------------------------------- checks
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL_A || state_r == S_MUL_K || state_r == S_MUL_P))
    else $error("multiplier finished outside a multiply step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished outside the gain step");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_K) |-> (k_r <= GAIN_W'(GAIN_ONE)))
    else $error("gain above 1.0");

  a_units_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
    else $error("arithmetic unit busy while idle");

endmodule

`default_nettype wire

// ===== sim/three_axis_smoothing_kalman_filter_checker.sv =====
// Estimate checker for the three-axis smoothing Kalman filter: watches both channels and
// the APB port, predicts each filtered sample and compares it with the one the block sends.
// Depends on tskf_pkg and the channel interfaces in tskf_if.
module three_axis_smoothing_kalman_filter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  tskf_in_if                            in_mon,
  tskf_out_if                           out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tskf_pkg::ADDR_W-1:0]   paddr,
  input  logic [tskf_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,
  output int unsigned                   error_count,
  output int unsigned                   awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tskf_pkg::*;

  localparam int  REPORT_LIMIT = 10;
  localparam longint EST_MAX   = 2 ** (SAMPLE_W - 1) - 1;
  localparam longint EST_MIN   = -(2 ** (SAMPLE_W - 1));

  typedef logic [AXES-1:0][SAMPLE_W-1:0] axes_t;

  logic [REG_W-1:0]           alpha_q16;
  logic [REG_W-1:0]           q_noise;
  logic [REG_W-1:0]           r_noise;
  logic signed [SAMPLE_W-1:0] estimate [AXES];
  logic [COV_W-1:0]           covariance;
  axes_t                      awaited_q [$];
  int unsigned                failures = 0;

  // Divide by 2^16, ties toward plus infinity.
  function automatic longint signed round_q16(input longint signed v);
    return (v + ROUND_HALF) >>> FRAC_W;
  endfunction

  // Advance the filter state by one sample and return the new estimates.
  function automatic axes_t filter_sample(input axes_t accel);
    longint signed p_pred, denom, gain, a, x, e, s, ne, p_next;
    axes_t         est_out;
    int            i;
    p_pred = longint'(covariance) + longint'(q_noise);
    if (p_pred > COV_MAX) p_pred = COV_MAX;
    denom = p_pred + longint'(r_noise);
    gain  = (denom == 0) ? 0 : (p_pred <<< FRAC_W) / denom;
    if (gain > GAIN_ONE) gain = GAIN_ONE;
    a = longint'(alpha_q16);
    for (i = 0; i < AXES; i++) begin
      x  = $signed(accel[i]);
      e  = estimate[i];
      s  = round_q16(a * x + (longint'(GAIN_ONE) - a) * e);
      ne = e + round_q16(gain * (s - e));
      if (ne > EST_MAX) ne = EST_MAX;
      if (ne < EST_MIN) ne = EST_MIN;
      estimate[i] = ne[SAMPLE_W-1:0];
      est_out[i]  = ne[SAMPLE_W-1:0];
    end
    p_next = (p_pred * (longint'(GAIN_ONE) - gain) + ROUND_HALF) >>> FRAC_W;
    if (p_next > COV_MAX) p_next = COV_MAX;
    covariance = p_next[COV_W-1:0];
    return est_out;
  endfunction

  always @(posedge clk) begin
    axes_t want;
    axes_t got;
    int    i;
    if (!rst_n) begin
      alpha_q16  = REG_W'(ALPHA_RST);
      q_noise    = REG_W'(Q_RST);
      r_noise    = REG_W'(R_RST);
      covariance = COV_W'(COV_RST);
      for (i = 0; i < AXES; i++) estimate[i] = '0;
      awaited_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.filtered_z, out_mon.filtered_y, out_mon.filtered_x};
        if (awaited_q.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("%t: estimate with no sample pending: x %0d y %0d z %0d", $realtime,
                     $signed(got[0]), $signed(got[1]), $signed(got[2]));
          failures++;
        end else begin
          want = awaited_q.pop_front();
          for (i = 0; i < AXES; i++) begin
            if (got[i] !== want[i]) begin
              if (failures < REPORT_LIMIT)
                $display("%t: axis %0d estimate differs: expected %0d, got %0d", $realtime,
                         i, $signed(want[i]), $signed(got[i]));
              failures++;
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:REG_LSB]))
          REG_ALPHA: alpha_q16 = pwdata[REG_W-1:0];
          REG_Q:     q_noise   = pwdata[REG_W-1:0];
          REG_R:     r_noise   = pwdata[REG_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        awaited_q.push_back(filter_sample({in_mon.accel_z, in_mon.accel_y, in_mon.accel_x}));
    end
    awaited_count <= awaited_q.size();
    error_count   <= failures;
  end

endmodule

// ===== sim/three_axis_smoothing_kalman_filter_tb.sv =====
// Top-level testbench for the three-axis smoothing Kalman filter: clock, reset, samples,
// APB register writes, output back-pressure and the final verdict.
// Depends on tskf_pkg, tskf_if, the RTL top and the estimate checker.
module three_axis_smoothing_kalman_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tskf_pkg::*;

  localparam int          CLK_HALF       = 5;
  localparam int          RESET_CYCLES   = 6;
  localparam int          SETTLE_CYCLES  = 80;
  localparam int          END_CYCLES     = 150;
  localparam int          HOLD_OFF_LEN   = 400;
  localparam int          PHASE_ITEMS    = 172;
  localparam int          ONE_G          = 2048;    // 1.0 G in Q4.11
  localparam int          JITTER         = 300;
  localparam longint      LIMIT_NS       = 30_000_000;
  localparam logic [1:0]  REG_BEYOND     = 2'd3;    // index past the register list

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int unsigned         error_count;
  int unsigned         awaited_count;

  // Idle behavior, set per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // A bump of hold_off_seq asks the receiver for one long hold-off.
  int unsigned hold_off_seq   = 0;

  tskf_in_if  in_ch ();
  tskf_out_if out_ch ();

  three_axis_smoothing_kalman_filter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  three_axis_smoothing_kalman_filter_checker estimate_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count   (error_count),
    .awaited_count (awaited_count)
  );

  always #CLK_HALF clk = ~clk;

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_seq != hold_seen) begin
        hold_seen = hold_off_seq;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Write one register through an APB setup phase and an access phase. Junk goes in the upper
  // bits of the data word, since the block keeps only the low 16.
  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] value);
    logic [DATA_W-1:0] word;
    word            = $urandom;
    word[REG_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_filter(input logic [REG_W-1:0] alpha, q, r);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_Q, q);
    write_reg(REG_R, r);
  endtask

  // Drop valid and hold until every sample has come back, then let the block settle.
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one sample after a random gap and hold it until the block takes it.
  // Valid stays high on return so that back-to-back samples need no extra edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] ax, ay, az);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= ax;
    in_ch.accel_y <= ay;
    in_ch.accel_z <= az;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly full-range noise, some readings near rest (1 G on Z), a few at the rails.
  task automatic send_random_sample();
    int unsigned            kind;
    logic [SAMPLE_W-1:0]    ax, ay, az;
    kind = $urandom_range(9);
    if (kind < 6) begin
      ax = SAMPLE_W'($urandom);
      ay = SAMPLE_W'($urandom);
      az = SAMPLE_W'($urandom);
    end else if (kind < 9) begin
      ax = SAMPLE_W'(int'($urandom_range(2 * JITTER)) - JITTER);
      ay = SAMPLE_W'(int'($urandom_range(2 * JITTER)) - JITTER);
      az = SAMPLE_W'(ONE_G + int'($urandom_range(2 * JITTER)) - JITTER);
    end else begin
      ax = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      ay = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      az = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    end
    send_sample(ax, ay, az);
  endtask

  // Pick a register value: low end, high end or anything between.
  function automatic logic [REG_W-1:0] pick_setting(input int unsigned lo);
    case ($urandom_range(3))
      0:       return REG_W'(lo);
      1:       return '1;
      default: return REG_W'($urandom_range(16'hFFFF, lo));
    endcase
  endfunction

  initial begin
    int unsigned send_pct [4];
    int unsigned stall_pct [4];
    int          mode;
    int          setting;
    int          n;
    send_pct  = '{0, 82, 0, 31};
    stall_pct = '{0, 0, 82, 31};

    in_ch.valid   = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    // Hold reset, then release it at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rails and mixed signs at the default weights.
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h8000, 16'h0001);
    send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h5555, 16'hAAAA, 16'h00FF);

    // Zero smoothing weight: the sample is ignored, the estimate holds.
    drain_block();
    write_reg(REG_ALPHA, 16'h0000);
    send_sample(16'h7FFF, 16'h8000, 16'h1234);

    // All registers at their top values.
    drain_block();
    write_filter(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h8000, 16'h7FFF, 16'h0800);
    send_sample(16'h7FFF, 16'h8000, 16'hF800);

    // Zero measurement noise: full gain, covariance collapses to zero.
    // With q also zero the next samples hit a zero gain denominator.
    drain_block();
    write_reg(REG_Q, 16'h0000);
    write_reg(REG_R, 16'h0000);
    send_sample(16'h1234, 16'h8000, 16'h7FFF);
    send_sample(16'h0400, 16'hFC00, 16'h0800);
    send_sample(16'h7FFF, 16'h7FFF, 16'h8000);

    // Smallest process noise brings the gain back to one.
    drain_block();
    write_reg(REG_Q, 16'h0001);
    send_sample(16'hAAAA, 16'h5555, 16'h0000);

    // Write past the register list: must change nothing.
    drain_block();
    write_reg(REG_BEYOND, 16'hFFFF);
    send_sample(16'h0123, 16'hFEDC, 16'h0800);

    // Back to the reset weights.
    drain_block();
    write_filter(REG_W'(ALPHA_RST), REG_W'(Q_RST), REG_W'(R_RST));
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0001, 16'h8001);

    // Random: every idle mode, two register settings each.
    for (mode = 0; mode < 4; mode++) begin
      for (setting = 0; setting < 2; setting++) begin
        drain_block();
        send_idle_pct  = send_pct[mode];
        recv_stall_pct = stall_pct[mode];
        write_filter(pick_setting(0), pick_setting(0), pick_setting(1));
        // Stall the output for a long stretch while samples keep coming, so the
        // block backs up into its input.
        if (mode == 0 && setting == 0) hold_off_seq++;
        for (n = 0; n < PHASE_ITEMS; n++) begin
          // Pause the sender once mid-phase until the pipeline is empty.
          if (mode == 0 && setting == 1 && n == PHASE_ITEMS / 2) drain_block();
          send_random_sample();
        end
      end
    end

    // Wind down: drop valid, wait for the last estimates and any stragglers.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tskf_pkg.sv
rtl/tskf_if.sv
rtl/tskf_mul.sv
rtl/tskf_div.sv
rtl/three_axis_smoothing_kalman_filter.sv
sim/three_axis_smoothing_kalman_filter_checker.sv
sim/three_axis_smoothing_kalman_filter_tb.sv
